@@ design/pta_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Phase tag averager package
// Shared constants, register map and widths for the phase tag averager.
// ----------------------------------------------------------------------------
package pta_pkg;

  // Channel and tag geometry
  localparam int NUM_CHANNELS = 8;
  localparam int CH_W         = 3;
  localparam int TAG_BITS     = 22;

  // One reference clock period in phase units
  localparam int PHASE_PERIOD = 1310720;
  localparam int PHASE_W      = 21;

  // Accumulator, sample counter and offset widths
  localparam int SUM_W = 48;
  localparam int CNT_W = 11;
  localparam int OFF_W = 32;

  // Register interface
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;
  localparam logic [CNT_W-1:0] AVG_LEN_RESET = CNT_W'(16);

  typedef enum logic [1:0] {
    REG_AVERAGE_COUNT     = 2'd0,
    REG_REVERSE_DIRECTION = 2'd1,
    REG_REFERENCE_CHANNEL = 2'd2
  } reg_addr_t;

  // Input actions
  localparam logic ACT_TAG   = 1'b0;
  localparam logic ACT_START = 1'b1;

  // Quadrant codes of the top two bits of the tag difference
  localparam logic [1:0] QUAD_LOW   = 2'd0;
  localparam logic [1:0] QUAD_RESET = 2'd1;
  localparam logic [1:0] QUAD_HIGH  = 2'd3;

endpackage

@@ design/pta_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Phase tag averager divider
// Restoring divider, one quotient bit per cycle: signed sum by an unsigned
// sample count, truncating toward zero.
// ----------------------------------------------------------------------------
module pta_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [pta_pkg::SUM_W-1:0]    dividend,
  input  logic        [pta_pkg::CNT_W-1:0]    divisor,
  output logic                                done,
  output logic signed [pta_pkg::SUM_W-1:0]    quotient
);

  localparam int STEP_W = $clog2(pta_pkg::SUM_W);

  logic                        busy_r;
  logic                        done_r;
  logic                        neg_r;
  logic [STEP_W-1:0]           step_r;
  logic [pta_pkg::CNT_W-1:0]   div_r;
  logic [pta_pkg::CNT_W-1:0]   rem_r;
  logic [pta_pkg::SUM_W-1:0]   quo_r;

  logic [pta_pkg::CNT_W:0]     rem_sh;
  logic [pta_pkg::CNT_W:0]     rem_sub;
  logic                        fits;
  logic [pta_pkg::SUM_W-1:0]   mag;

  // Magnitude of the dividend; the most negative value maps to 2^47
  assign mag = dividend[pta_pkg::SUM_W-1] ? (~dividend + 1'b1) : dividend;

  // One restoring step: shift in the next dividend bit and try to subtract
  assign rem_sh  = {rem_r, quo_r[pta_pkg::SUM_W-1]};
  assign rem_sub = rem_sh - {1'b0, div_r};
  assign fits    = (rem_sh >= {1'b0, div_r});

  // Sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        neg_r  <= dividend[pta_pkg::SUM_W-1];
        quo_r  <= mag;
        rem_r  <= '0;
        div_r  <= divisor;
        step_r <= STEP_W'(pta_pkg::SUM_W - 1);
      end else if (busy_r) begin
        if (fits) begin
          rem_r <= rem_sub[pta_pkg::CNT_W-1:0];
          quo_r <= {quo_r[pta_pkg::SUM_W-2:0], 1'b1};
        end else begin
          rem_r <= rem_sh[pta_pkg::CNT_W-1:0];
          quo_r <= {quo_r[pta_pkg::SUM_W-2:0], 1'b0};
        end
        if (step_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          step_r <= step_r - 1'b1;
        end
      end
    end
  end

  // Restore the sign of the quotient
  assign done     = done_r;
  assign quotient = neg_r ? $signed(~quo_r + 1'b1) : $signed(quo_r);

endmodule

@@ design/phase_tag_averager.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Phase tag averager
// Per-channel phase tracker that unwraps, sums and averages tag differences
// against a reference channel and folds the result into one clock period.
// ----------------------------------------------------------------------------
// The block takes one item at a time. A start, a reference tag or a tag on a
// disabled channel passes S_DECODE only; a tag that adds to its channel's sum
// also passes S_SUM. A tag that completes an average then passes S_DIV, where
// the shared divider produces one quotient bit per cycle over the 48-bit sum,
// S_OFFSET, S_FOLD and S_OUT. The finished result sits in an output register,
// so the result channel may stall without losing it; a further completed
// average waits for that register to be free.
// ----------------------------------------------------------------------------
module phase_tag_averager (
  input  logic                               clk,
  input  logic                               rst_n,
  // Register port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [pta_pkg::ADDR_W-1:0]         paddr,
  input  logic [pta_pkg::DATA_W-1:0]         pwdata,
  output logic [pta_pkg::DATA_W-1:0]         prdata,
  output logic                               pready,
  // Input channel
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_action,
  input  logic [pta_pkg::CH_W-1:0]           in_channel,
  input  logic [pta_pkg::TAG_BITS-1:0]       in_tag_value,
  // Result channel
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [pta_pkg::CH_W-1:0]           out_result_channel,
  output logic [pta_pkg::PHASE_W-1:0]        out_phase,
  output logic                               out_ready_res
);

  localparam int NCH   = pta_pkg::NUM_CHANNELS;
  localparam int SUM_W = pta_pkg::SUM_W;
  localparam int ACC_W = SUM_W + 2;
  localparam int TAG_W = pta_pkg::TAG_BITS;
  localparam int OFF_W = pta_pkg::OFF_W;
  localparam int CNT_W = pta_pkg::CNT_W;

  localparam logic signed [ACC_W-1:0] SUM_MAX    = ACC_W'((64'(1) <<< (SUM_W - 1)) - 1);
  localparam logic signed [ACC_W-1:0] SUM_MIN    = -SUM_MAX - 1'b1;
  localparam logic signed [ACC_W-1:0] PERIOD     = ACC_W'(pta_pkg::PHASE_PERIOD);
  localparam logic        [OFF_W-1:0] PERIOD_OFF = OFF_W'(pta_pkg::PHASE_PERIOD);
  localparam logic        [OFF_W-1:0] UNWRAP_STEP = OFF_W'(64'(1) << TAG_W);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SUM,
    S_DIV,
    S_OFFSET,
    S_FOLD,
    S_OUT
  } state_t;

  // Configuration registers
  logic [CNT_W-1:0]              avg_len_r;
  logic                          reverse_r;
  logic [pta_pkg::CH_W-1:0]      ref_channel_r;

  // Tracker state
  logic [TAG_W-1:0]              ref_tag_r;
  logic                          enabled_r   [NCH];
  logic                          ready_flag_r[NCH];
  logic [1:0]                    prev_quad_r [NCH];
  logic [OFF_W-1:0]              unwrap_r    [NCH];
  logic signed [SUM_W-1:0]       sum_r       [NCH];
  logic [CNT_W-1:0]              count_r     [NCH];
  logic [OFF_W-1:0]              offset_r    [NCH];

  // Sequencer and working registers
  state_t                        state_r;
  logic                          action_r;
  logic [pta_pkg::CH_W-1:0]      ch_r;
  logic [TAG_W-1:0]              tag_r;
  logic [TAG_W-1:0]              delta_r;
  logic signed [SUM_W-1:0]       avg_r;
  logic signed [ACC_W-1:0]       phase_r;
  logic [pta_pkg::PHASE_W-1:0]   res_phase_r;
  logic                          res_ready_r;

  // Result register
  logic                          out_valid_r;
  logic [pta_pkg::CH_W-1:0]      out_channel_r;
  logic [pta_pkg::PHASE_W-1:0]   out_phase_r;
  logic                          out_ready_res_r;

  // Combinational helpers
  logic                          ch_ok;
  logic [TAG_W-1:0]              delta_nxt;
  logic [1:0]                    quad_nxt;
  logic [OFF_W-1:0]              unwrap_nxt;
  logic signed [ACC_W-1:0]       acc_raw;
  logic signed [SUM_W-1:0]       acc_nxt;
  logic [CNT_W-1:0]              count_nxt;
  logic [CNT_W-1:0]              n_eff;
  logic                          fold_hi;
  logic                          fold_lo;
  logic signed [ACC_W-1:0]       fold_val;
  logic [pta_pkg::PHASE_W-1:0]   phase_nxt;
  logic                          cfg_write;
  logic                          div_start;
  logic                          div_done;
  logic signed [SUM_W-1:0]       div_quo;

  // Register port decode
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_comb begin
    prdata = '0;
    unique case (pta_pkg::reg_addr_t'(paddr[3:2]))
      pta_pkg::REG_AVERAGE_COUNT:     prdata = pta_pkg::DATA_W'(avg_len_r);
      pta_pkg::REG_REVERSE_DIRECTION: prdata = pta_pkg::DATA_W'(reverse_r);
      pta_pkg::REG_REFERENCE_CHANNEL: prdata = pta_pkg::DATA_W'(ref_channel_r);
      default:                        prdata = '0;
    endcase
  end

  // Tag difference, quadrant tracking and unwrap step
  assign ch_ok     = (int'(ch_r) < NCH);
  assign delta_nxt = reverse_r ? (tag_r - ref_tag_r) : (ref_tag_r - tag_r);
  assign quad_nxt  = delta_nxt[TAG_W-1 -: 2];

  always_comb begin
    unwrap_nxt = unwrap_r[ch_r];
    if (prev_quad_r[ch_r] == pta_pkg::QUAD_LOW && quad_nxt == pta_pkg::QUAD_HIGH) begin
      unwrap_nxt = unwrap_r[ch_r] - UNWRAP_STEP;
    end else if (prev_quad_r[ch_r] == pta_pkg::QUAD_HIGH &&
                 quad_nxt == pta_pkg::QUAD_LOW) begin
      unwrap_nxt = unwrap_r[ch_r] + UNWRAP_STEP;
    end
  end

  // Saturating accumulate of the unwrapped difference
  assign acc_raw = $signed({{2{sum_r[ch_r][SUM_W-1]}}, sum_r[ch_r]})
                 + $signed({{(ACC_W-TAG_W){1'b0}}, delta_r})
                 + $signed({{(ACC_W-OFF_W){unwrap_r[ch_r][OFF_W-1]}}, unwrap_r[ch_r]});

  always_comb begin
    if (acc_raw > SUM_MAX) begin
      acc_nxt = SUM_MAX[SUM_W-1:0];
    end else if (acc_raw < SUM_MIN) begin
      acc_nxt = SUM_MIN[SUM_W-1:0];
    end else begin
      acc_nxt = acc_raw[SUM_W-1:0];
    end
  end

  assign count_nxt = count_r[ch_r] + 1'b1;
  assign n_eff     = (avg_len_r == '0) ? CNT_W'(1) : avg_len_r;
  assign div_start = (state_r == S_SUM) && (count_nxt >= n_eff);

  // Fold into one period, then clamp what one fold could not reach
  assign fold_hi = (phase_r >= PERIOD);
  assign fold_lo = (phase_r < 0);

  always_comb begin
    if (fold_hi) begin
      fold_val = phase_r - PERIOD;
    end else if (fold_lo) begin
      fold_val = phase_r + PERIOD;
    end else begin
      fold_val = phase_r;
    end
    if (fold_val < 0) begin
      phase_nxt = '0;
    end else if (fold_val >= PERIOD) begin
      phase_nxt = pta_pkg::PHASE_W'(pta_pkg::PHASE_PERIOD - 1);
    end else begin
      phase_nxt = fold_val[pta_pkg::PHASE_W-1:0];
    end
  end

  // Shared divider
  pta_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (acc_nxt),
    .divisor  (n_eff),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Sequencer, tracker state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      avg_len_r     <= pta_pkg::AVG_LEN_RESET;
      reverse_r     <= 1'b0;
      ref_channel_r <= '0;
      ref_tag_r     <= '0;
      out_valid_r   <= 1'b0;
      for (int i = 0; i < NCH; i++) begin
        enabled_r[i]    <= 1'b0;
        ready_flag_r[i] <= 1'b0;
        prev_quad_r[i]  <= pta_pkg::QUAD_RESET;
        unwrap_r[i]     <= '0;
        sum_r[i]        <= '0;
        count_r[i]      <= '0;
        offset_r[i]     <= '0;
      end
    end else begin
      // Register writes
      if (cfg_write) begin
        unique case (pta_pkg::reg_addr_t'(paddr[3:2]))
          pta_pkg::REG_AVERAGE_COUNT:     avg_len_r     <= pwdata[CNT_W-1:0];
          pta_pkg::REG_REVERSE_DIRECTION: reverse_r     <= pwdata[0];
          pta_pkg::REG_REFERENCE_CHANNEL: ref_channel_r <= pwdata[pta_pkg::CH_W-1:0];
          default: ;
        endcase
      end

      // A result leaves on its transfer; in S_OUT the next result replaces it
      if (out_valid_r && out_ready && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            action_r <= in_action;
            ch_r     <= in_channel;
            tag_r    <= in_tag_value;
            state_r  <= S_DECODE;
          end
        end

        S_DECODE: begin
          state_r <= S_IDLE;
          if (action_r == pta_pkg::ACT_START) begin
            // Start: re-arm the tracker, keeping its phase offset
            if (ch_ok) begin
              enabled_r[ch_r]    <= 1'b1;
              ready_flag_r[ch_r] <= 1'b0;
              prev_quad_r[ch_r]  <= pta_pkg::QUAD_RESET;
              unwrap_r[ch_r]     <= '0;
              sum_r[ch_r]        <= '0;
              count_r[ch_r]      <= '0;
            end
          end else if (ch_r == ref_channel_r) begin
            ref_tag_r <= tag_r;
          end else if (ch_ok && enabled_r[ch_r]) begin
            delta_r           <= delta_nxt;
            prev_quad_r[ch_r] <= quad_nxt;
            unwrap_r[ch_r]    <= unwrap_nxt;
            state_r           <= S_SUM;
          end
        end

        S_SUM: begin
          if (div_start) begin
            sum_r[ch_r]   <= '0;
            count_r[ch_r] <= '0;
            state_r       <= S_DIV;
          end else begin
            sum_r[ch_r]   <= acc_nxt;
            count_r[ch_r] <= count_nxt;
            state_r       <= S_IDLE;
          end
        end

        S_DIV: begin
          if (div_done) begin
            avg_r   <= div_quo;
            state_r <= S_OFFSET;
          end
        end

        S_OFFSET: begin
          phase_r <= $signed({{2{avg_r[SUM_W-1]}}, avg_r})
                   + $signed({{(ACC_W-OFF_W){offset_r[ch_r][OFF_W-1]}}, offset_r[ch_r]});
          state_r <= S_FOLD;
        end

        S_FOLD: begin
          res_phase_r <= phase_nxt;
          if (fold_hi) begin
            offset_r[ch_r] <= offset_r[ch_r] - PERIOD_OFF;
            res_ready_r    <= ready_flag_r[ch_r];
          end else if (fold_lo) begin
            offset_r[ch_r] <= offset_r[ch_r] + PERIOD_OFF;
            res_ready_r    <= ready_flag_r[ch_r];
          end else begin
            ready_flag_r[ch_r] <= 1'b1;
            res_ready_r        <= 1'b1;
          end
          state_r <= S_OUT;
        end

        S_OUT: begin
          // Wait until the result register is free
          if (!out_valid_r || out_ready) begin
            out_valid_r     <= 1'b1;
            out_channel_r   <= ch_r;
            out_phase_r     <= res_phase_r;
            out_ready_res_r <= res_ready_r;
            state_r         <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready           = (state_r == S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_result_channel = out_channel_r;
  assign out_phase          = out_phase_r;
  assign out_ready_res      = out_ready_res_r;

endmodule

@@ bench/tb_phase_tag_averager.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Phase tag averager testbench
// Drives tag and start transfers into the averager, predicts every averaged
// phase with a behavioural model of the tracker, and checks each result
// field by field. A directed sequence covers the corner cases, then several
// register settings run drifting tag streams with some noise, under random
// sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_phase_tag_averager;

  localparam int NUM_CHANNELS = pta_pkg::NUM_CHANNELS;
  localparam int CH_W         = pta_pkg::CH_W;
  localparam int TAG_BITS     = pta_pkg::TAG_BITS;
  localparam int PHASE_PERIOD = pta_pkg::PHASE_PERIOD;
  localparam int PHASE_W      = pta_pkg::PHASE_W;
  localparam int SUM_W        = pta_pkg::SUM_W;
  localparam int CNT_W        = pta_pkg::CNT_W;
  localparam int ADDR_W       = pta_pkg::ADDR_W;
  localparam int DATA_W       = pta_pkg::DATA_W;

  localparam int IDLE_LIMIT    = 2000;
  localparam int SETTLE_CYCLES = 16;
  localparam int DRAIN_CYCLES  = 80;

  localparam longint SUM_MAX = (longint'(1) << (SUM_W - 1)) - 1;
  localparam longint SUM_MIN = -(longint'(1) << (SUM_W - 1));

  // Register settings per phase; -1 asks for a random value.
  localparam int NUM_PHASES = 7;
  localparam int PLAN_AVG   [NUM_PHASES] = '{1, 4, 1024, 0, 3, 2, -1};
  localparam int PLAN_REV   [NUM_PHASES] = '{1, 0, 1, 0, 1, 0, -1};
  localparam int PLAN_REF   [NUM_PHASES] = '{3, 7, 0, 0, 5, 2, -1};
  localparam int PLAN_ITEMS [NUM_PHASES] = '{170, 170, 60, 120, 170, 170, 200};

  typedef pta_pkg::reg_addr_t reg_addr_t;

  typedef struct {
    bit [CH_W-1:0]    channel;
    bit [PHASE_W-1:0] phase;
    bit               ready;
  } phase_result_t;

  typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN, RX_SLOW} rx_mode_t;

  // Tracker model and the queue of averaged phases still to arrive.
  class phase_scoreboard;
    bit [CNT_W-1:0]    avg_len;
    bit                reverse;
    bit [CH_W-1:0]     ref_channel;
    bit [TAG_BITS-1:0] ref_tag;
    bit                tracking     [NUM_CHANNELS];
    bit                sticky_ready [NUM_CHANNELS];
    bit [1:0]          prev_quad    [NUM_CHANNELS];
    int                unwrap       [NUM_CHANNELS];
    longint            sum_acc      [NUM_CHANNELS];
    bit [CNT_W-1:0]    samples      [NUM_CHANNELS];
    int                offset       [NUM_CHANNELS];
    phase_result_t     expected_q[$];
    int                errors;
    int                results;
    int                folds;
    int                clamps;

    function new();
      avg_len     = pta_pkg::AVG_LEN_RESET;
      reverse     = 1'b0;
      ref_channel = '0;
      ref_tag     = '0;
      foreach (tracking[i]) begin
        tracking[i]     = 1'b0;
        sticky_ready[i] = 1'b0;
        prev_quad[i]    = pta_pkg::QUAD_RESET;
        unwrap[i]       = 0;
        sum_acc[i]      = 0;
        samples[i]      = '0;
        offset[i]       = 0;
      end
      errors  = 0;
      results = 0;
      folds   = 0;
      clamps  = 0;
    endfunction

    function void write_reg(reg_addr_t idx, bit [DATA_W-1:0] value);
      case (idx)
        pta_pkg::REG_AVERAGE_COUNT:     avg_len = value[CNT_W-1:0];
        pta_pkg::REG_REVERSE_DIRECTION: reverse = value[0];
        pta_pkg::REG_REFERENCE_CHANNEL: ref_channel = value[CH_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_input(bit action, bit [CH_W-1:0] ch, bit [TAG_BITS-1:0] tag);
      bit [TAG_BITS-1:0] diff;
      bit [1:0]          quad;
      longint            acc;
      longint            divisor;
      longint            ph;
      phase_result_t     res;
      // A start re-arms the tracker but leaves its phase offset alone.
      if (action == pta_pkg::ACT_START) begin
        tracking[ch]     = 1'b1;
        sticky_ready[ch] = 1'b0;
        prev_quad[ch]    = pta_pkg::QUAD_RESET;
        unwrap[ch]       = 0;
        sum_acc[ch]      = 0;
        samples[ch]      = '0;
        return;
      end
      if (ch == ref_channel) begin
        ref_tag = tag;
        return;
      end
      if (!tracking[ch])
        return;

      // Wrapped difference and quadrant unwrap.
      diff = reverse ? tag - ref_tag : ref_tag - tag;
      quad = diff[TAG_BITS-1 -: 2];
      if (prev_quad[ch] == pta_pkg::QUAD_LOW && quad == pta_pkg::QUAD_HIGH)
        unwrap[ch] -= (1 << TAG_BITS);
      else if (prev_quad[ch] == pta_pkg::QUAD_HIGH && quad == pta_pkg::QUAD_LOW)
        unwrap[ch] += (1 << TAG_BITS);
      prev_quad[ch] = quad;

      // Saturating accumulation.
      acc = sum_acc[ch] + longint'(diff) + longint'(unwrap[ch]);
      if (acc > SUM_MAX)
        acc = SUM_MAX;
      if (acc < SUM_MIN)
        acc = SUM_MIN;
      sum_acc[ch] = acc;
      samples[ch] = samples[ch] + 1'b1;

      divisor = (avg_len == 0) ? 1 : longint'(avg_len);
      if (longint'(samples[ch]) < divisor)
        return;

      // Average, add the channel offset and fold once into one period.
      ph = acc / divisor + longint'(offset[ch]);
      if (ph >= PHASE_PERIOD) begin
        ph -= PHASE_PERIOD;
        offset[ch] -= PHASE_PERIOD;
        folds++;
      end else if (ph < 0) begin
        ph += PHASE_PERIOD;
        offset[ch] += PHASE_PERIOD;
        folds++;
      end else begin
        sticky_ready[ch] = 1'b1;
      end
      if (ph < 0 || ph >= PHASE_PERIOD)
        clamps++;
      if (ph < 0)
        ph = 0;
      if (ph >= PHASE_PERIOD)
        ph = PHASE_PERIOD - 1;

      sum_acc[ch] = 0;
      samples[ch] = '0;
      res.channel = ch;
      res.phase   = ph[PHASE_W-1:0];
      res.ready   = sticky_ready[ch];
      expected_q.push_back(res);
    endfunction

    function void check_result(bit [CH_W-1:0] ch, bit [PHASE_W-1:0] phase, bit rdy);
      phase_result_t want;
      results++;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, channel %0d phase %0d ready %0d",
                 $time, ch, phase, rdy);
        return;
      end
      want = expected_q.pop_front();
      if (want.channel != ch) begin
        errors++;
        $display("%0t: result channel mismatch, expected %0d, actual %0d",
                 $time, want.channel, ch);
      end
      if (want.phase != phase) begin
        errors++;
        $display("%0t: phase mismatch on channel %0d, expected %0d, actual %0d",
                 $time, want.channel, want.phase, phase);
      end
      if (want.ready != rdy) begin
        errors++;
        $display("%0t: ready flag mismatch on channel %0d, expected %0d, actual %0d",
                 $time, want.channel, want.ready, rdy);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                clk;
  logic                rst_n        = 1'b0;
  logic                psel         = 1'b0;
  logic                penable      = 1'b0;
  logic                pwrite       = 1'b0;
  logic [ADDR_W-1:0]   paddr        = '0;
  logic [DATA_W-1:0]   pwdata       = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;
  logic                in_valid     = 1'b0;
  logic                in_ready;
  logic                in_action    = 1'b0;
  logic [CH_W-1:0]     in_channel   = '0;
  logic [TAG_BITS-1:0] in_tag_value = '0;
  logic                out_valid;
  logic                out_ready    = 1'b0;
  logic [CH_W-1:0]     out_result_channel;
  logic [PHASE_W-1:0]  out_phase;
  logic                out_ready_res;

  phase_scoreboard sb = new();

  // Stimulus shaping state.
  int                burst_left = 0;
  int                sent       = 0;
  int                settings   = 0;
  int                quiet      = 0;
  bit [CH_W-1:0]     gen_ref_ch = '0;
  bit [TAG_BITS-1:0] gen_ref_tag = '0;
  bit [TAG_BITS-1:0] drift [NUM_CHANNELS];

  // Receiver stall state.
  rx_mode_t    rx_mode    = RX_ALWAYS;
  int unsigned rx_cycle   = 0;
  bit [7:0]    rx_pattern = 8'b1011_0110;

  phase_tag_averager u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_action          (in_action),
    .in_channel         (in_channel),
    .in_tag_value       (in_tag_value),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_result_channel (out_result_channel),
    .out_phase          (out_phase),
    .out_ready_res      (out_ready_res)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Receiver: out_ready follows a stall mode that is picked afresh at random.
  always @(posedge clk) begin
    if (rx_cycle % 64 == 0) begin
      rx_mode    = rx_mode_t'($urandom_range(0, 3));
      rx_pattern = 8'($urandom);
    end
    case (rx_mode)
      RX_ALWAYS:  out_ready <= 1'b1;
      RX_RANDOM:  out_ready <= 1'($urandom_range(0, 1));
      RX_PATTERN: out_ready <= rx_pattern[rx_cycle % 8];
      default:    out_ready <= (rx_cycle % 24 == 0);
    endcase
    rx_cycle++;
  end

  // Monitor: results are checked before the same edge's input is noted.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready)
        sb.check_result(out_result_channel, out_phase, out_ready_res);
      if (in_valid && in_ready)
        sb.note_input(in_action, in_channel, in_tag_value);
      if (psel && penable && pwrite && pready)
        sb.write_reg(reg_addr_t'(paddr[ADDR_W-1:2]), pwdata);
      if ((out_valid && out_ready) || (in_valid && in_ready) ||
          (psel && penable && pwrite && pready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= IDLE_LIMIT) begin
        $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                 $time, IDLE_LIMIT, sb.pending());
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Register write: setup cycle, access cycle, then an idle cycle.
  task automatic reg_write(reg_addr_t idx, bit [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    if (idx == pta_pkg::REG_REFERENCE_CHANNEL)
      gen_ref_ch = value[CH_W-1:0];
  endtask

  // One input transfer, followed by a gap when the current burst runs out.
  task automatic push_item(bit action, bit [CH_W-1:0] ch, bit [TAG_BITS-1:0] tag);
    int gap;
    in_valid     <= 1'b1;
    in_action    <= action;
    in_channel   <= ch;
    in_tag_value <= tag;
    do @(posedge clk); while (in_ready !== 1'b1);
    sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Hold the sender until every predicted phase has been received. The first
  // edge lets the monitor note the last transfer before the queue is polled.
  task automatic wait_results(int settle);
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // Mostly tags drifting around the reference, some starts and some noise.
  task automatic gen_item(output bit action, output bit [CH_W-1:0] ch,
                          output bit [TAG_BITS-1:0] tag);
    int r;
    r = $urandom_range(0, 99);
    if (r < 6) begin
      action = pta_pkg::ACT_START;
      ch     = CH_W'($urandom_range(0, NUM_CHANNELS - 1));
      tag    = TAG_BITS'($urandom);
    end else if (r < 20) begin
      gen_ref_tag = TAG_BITS'(gen_ref_tag + $urandom_range(1, 4000));
      action = pta_pkg::ACT_TAG;
      ch     = gen_ref_ch;
      tag    = gen_ref_tag;
    end else if (r < 90) begin
      do ch = CH_W'($urandom_range(0, NUM_CHANNELS - 1)); while (ch == gen_ref_ch);
      if ($urandom_range(0, 49) == 0)
        drift[ch] = TAG_BITS'($urandom);
      else
        drift[ch] = TAG_BITS'(drift[ch] + $urandom_range(0, 256) - 128);
      action = pta_pkg::ACT_TAG;
      tag    = TAG_BITS'(gen_ref_tag + drift[ch] + $urandom_range(0, 31) - 16);
    end else begin
      action = 1'($urandom_range(0, 1));
      ch     = CH_W'($urandom_range(0, NUM_CHANNELS - 1));
      tag    = TAG_BITS'($urandom);
    end
  endtask

  initial begin
    bit                action;
    bit [CH_W-1:0]     ch;
    bit [TAG_BITS-1:0] tag;
    int                avg;
    int                rev;
    int                refc;

    foreach (drift[i])
      drift[i] = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed corner cases, one sample per average.
    reg_write(pta_pkg::REG_AVERAGE_COUNT, 1);
    reg_write(pta_pkg::REG_REVERSE_DIRECTION, 0);
    reg_write(pta_pkg::REG_REFERENCE_CHANNEL, 0);
    settings++;
    // A tag on a channel that was never started is dropped.
    push_item(pta_pkg::ACT_TAG, 3'd5, 22'h155555);
    push_item(pta_pkg::ACT_START, 3'd1, 22'h000000);
    // Starting the reference channel does not stop it acting as reference.
    push_item(pta_pkg::ACT_START, 3'd0, 22'h2AAAAA);
    push_item(pta_pkg::ACT_TAG, 3'd0, 22'h3FFFFF);
    // Zero difference: in range, so the ready flag is set.
    push_item(pta_pkg::ACT_TAG, 3'd1, 22'h3FFFFF);
    // Quadrant 0 to 3 gives a small negative phase that folds upwards.
    push_item(pta_pkg::ACT_TAG, 3'd1, 22'h000004);
    // Re-arm clears the flag but keeps the offset, so the next one folds down.
    push_item(pta_pkg::ACT_START, 3'd1, 22'h000000);
    push_item(pta_pkg::ACT_TAG, 3'd1, 22'h3FFFFF);
    // Differences beyond two periods need clamping after the single fold.
    push_item(pta_pkg::ACT_TAG, 3'd1, 22'h12393F);
    push_item(pta_pkg::ACT_TAG, 3'd1, 22'h12393F);
    // Quadrant 3 to 0 steps the unwrap offset up.
    push_item(pta_pkg::ACT_TAG, 3'd1, 22'h00000F);
    push_item(pta_pkg::ACT_TAG, 3'd1, 22'h3FFFEF);
    push_item(pta_pkg::ACT_START, 3'd7, 22'h3FFFFF);
    push_item(pta_pkg::ACT_TAG, 3'd7, 22'h000000);
    push_item(pta_pkg::ACT_TAG, 3'd0, 22'h000000);

    // Random phases, each under its own register setting.
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_results(SETTLE_CYCLES);
      avg  = (PLAN_AVG[p] < 0) ? $urandom_range(1, 8) : PLAN_AVG[p];
      rev  = (PLAN_REV[p] < 0) ? $urandom_range(0, 1) : PLAN_REV[p];
      refc = (PLAN_REF[p] < 0) ? $urandom_range(0, NUM_CHANNELS - 1) : PLAN_REF[p];
      reg_write(pta_pkg::REG_AVERAGE_COUNT, DATA_W'(avg));
      reg_write(pta_pkg::REG_REVERSE_DIRECTION, DATA_W'(rev));
      reg_write(pta_pkg::REG_REFERENCE_CHANNEL, DATA_W'(refc));
      settings++;
      for (int i = 0; i < PLAN_ITEMS[p]; i++) begin
        gen_item(action, ch, tag);
        push_item(action, ch, tag);
        if ($urandom_range(0, 149) == 0)
          wait_results(1);
      end
    end

    wait_results(DRAIN_CYCLES);
    $display("Run covered %0d input transfers and %0d phase results over %0d settings.",
             sent, sb.results, settings);
    $display("%0d averages were folded and %0d of those clamped.", sb.folds, sb.clamps);
    if (sb.errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

@@ filelist.f @@
design/pta_pkg.sv
design/pta_div.sv
design/phase_tag_averager.sv
bench/tb_phase_tag_averager.sv
